FILE: rtl/set_assoc_cache_tag_replacement_defines.svh
// ---------------------------------------------------------------------------
// set_assoc_cache_tag_replacement_defines
// Assertion macros for the cache tag block.
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_REPLACEMENT_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_REPLACEMENT_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define SACT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define SACT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sact_pkg.sv
// ---------------------------------------------------------------------------
// sact_pkg
// Shared types and constants of the set-associative cache tag block.
// ---------------------------------------------------------------------------
`default_nettype none
package sact_pkg;
    localparam int ADDR_BITS = 16;
    localparam int WAYS      = 4;
    localparam int MAX_SETS  = 256;
    localparam int WAY_W     = 2;
    localparam int SET_W     = 8;
    localparam int TAG_W     = 16;
    localparam int CNT_W     = 16;
    localparam int RANK_W    = 2;
    localparam int PLRU_W    = 3;

    localparam logic [2:0] POL_LRU  = 3'd0;
    localparam logic [2:0] POL_MRU  = 3'd1;
    localparam logic [2:0] POL_FIFO = 3'd2;
    localparam logic [2:0] POL_PLRU = 3'd3;
    localparam logic [2:0] POL_LFU  = 3'd4;

    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_INDEX  = 2'd1;
    localparam logic [1:0] REG_POLICY = 2'd2;

    // one stored entry of a set (all ways)
    typedef struct packed {
        logic [WAYS-1:0][TAG_W-1:0]  tags;
        logic [WAYS-1:0]             valid;
        logic [WAYS-1:0][RANK_W-1:0] rank;
        logic [WAYS-1:0][CNT_W-1:0]  cnt;
        logic [WAY_W-1:0]            fifo;
        logic [PLRU_W-1:0]           plru;
    } t_set;

    // lookup result handed back to the top
    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
    } t_res;
endpackage
`default_nettype wire

FILE: rtl/sact_update.sv
// ---------------------------------------------------------------------------
// sact_update
// Tag compare, victim choice and policy state update for one set.
// ---------------------------------------------------------------------------
`default_nettype none
module sact_update (
    input  wire sact_pkg::t_set           i_set,
    input  wire logic [sact_pkg::TAG_W-1:0] i_tag,
    input  wire logic [2:0]               i_policy,
    output sact_pkg::t_set                o_set,
    output sact_pkg::t_res                o_res
);
    logic                          hit;
    logic                          found;
    logic [sact_pkg::WAY_W-1:0]    hway;
    logic [sact_pkg::WAY_W-1:0]    iway;
    logic [sact_pkg::WAY_W-1:0]    vict;
    logic [sact_pkg::WAY_W-1:0]    way;
    logic [sact_pkg::WAY_W-1:0]    lmax;
    logic                          lfound;
    logic                          mfound;
    logic [sact_pkg::WAY_W-1:0]    mway;
    logic [sact_pkg::WAY_W-1:0]    fway;
    logic [sact_pkg::WAY_W-1:0]    bway;
    logic [sact_pkg::RANK_W-1:0]   old;
    logic [sact_pkg::CNT_W-1:0]    c;

    // hit search, lowest way wins
    always_comb begin
        hit  = 1'b0;
        hway = '0;
        for (int w = sact_pkg::WAYS - 1; w >= 0; w--) begin
            if (i_set.valid[w] && i_set.tags[w] == i_tag) begin
                hit  = 1'b1;
                hway = w[sact_pkg::WAY_W-1:0];
            end
        end
    end

    // lowest invalid way
    always_comb begin
        found = 1'b0;
        iway  = '0;
        for (int w = sact_pkg::WAYS - 1; w >= 0; w--) begin
            if (!i_set.valid[w]) begin
                found = 1'b1;
                iway  = w[sact_pkg::WAY_W-1:0];
            end
        end
    end

    // victim candidates
    always_comb begin
        lfound = 1'b0;
        fway   = '0;
        mfound = 1'b0;
        mway   = '0;
        lmax   = '0;
        bway   = '0;
        for (int w = sact_pkg::WAYS - 1; w >= 0; w--) begin
            if (i_set.rank[w] == 2'(sact_pkg::WAYS - 1)) begin
                lfound = 1'b1;
                fway   = w[sact_pkg::WAY_W-1:0];
            end
            if (i_set.rank[w] == '0) begin
                mfound = 1'b1;
                mway   = w[sact_pkg::WAY_W-1:0];
            end
        end
        for (int w = 1; w < sact_pkg::WAYS; w++) begin
            if (i_set.rank[w] > i_set.rank[lmax]) lmax = w[sact_pkg::WAY_W-1:0];
            if (i_set.cnt[w] < i_set.cnt[bway]) bway = w[sact_pkg::WAY_W-1:0];
        end
    end

    always_comb begin
        case (i_policy)
            sact_pkg::POL_MRU:  vict = mfound ? mway : '0;
            sact_pkg::POL_FIFO: vict = i_set.fifo;
            sact_pkg::POL_PLRU: vict = i_set.plru[1] ?
                                       {1'b1, i_set.plru[0] ? 1'b1 : 1'b0} :
                                       {1'b0, i_set.plru[2]};
            sact_pkg::POL_LFU:  vict = bway;
            default:            vict = lfound ? fway : lmax;
        endcase
    end

    // touch the chosen way
    always_comb begin
        way   = hit ? hway : (found ? iway : vict);
        o_set = i_set;
        if (!hit && !found && i_policy == sact_pkg::POL_FIFO)
            o_set.fifo = i_set.fifo + 1'b1;
        old = i_set.valid[way] ? i_set.rank[way] : 2'(sact_pkg::WAYS - 1);
        for (int v = 0; v < sact_pkg::WAYS; v++) begin
            if (v[sact_pkg::WAY_W-1:0] != way && i_set.valid[v] &&
                i_set.rank[v] < old && i_set.rank[v] != 2'(sact_pkg::WAYS - 1))
                o_set.rank[v] = i_set.rank[v] + 1'b1;
        end
        o_set.rank[way] = '0;
        // tree bits: node1 -> bit1, node2 -> bit2, node3 -> bit3 (stored [0])
        o_set.plru[1] = ~way[1];
        if (way[1]) o_set.plru[0] = ~way[0];
        else        o_set.plru[2] = ~way[0];
        c = hit ? i_set.cnt[way] : '0;
        o_set.cnt[way] = (c == '1) ? c : c + 1'b1;
        o_set.tags[way]  = i_tag;
        o_set.valid[way] = 1'b1;
        o_res.hit = hit;
        o_res.way = way;
    end
endmodule
`default_nettype wire

FILE: rtl/set_assoc_cache_tag_replacement.sv
// ---------------------------------------------------------------------------
// set_assoc_cache_tag_replacement
// 4-way tag array with LRU, MRU, FIFO, tree PLRU and LFU replacement.
// ---------------------------------------------------------------------------
//  channel | direction | handshake
//  request | in        | i_valid / o_stall
//  result  | out       | o_valid / i_stall
//  config  | in        | i_cfg_we, i_cfg_index, i_cfg_data
// An access is a set and seen-bit memory read, then a write-back.
// After reset a clearing pass over all 256 rows empties the set memory and
// seen memory (256 rows of 256 bits); no request is taken meanwhile.
// A result waits in the output register; the next request is read while it
// waits, and held in the write-back stage until the output register frees.
`default_nettype none
`include "set_assoc_cache_tag_replacement_defines.svh"
module set_assoc_cache_tag_replacement (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_address,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_hit,
    output logic [1:0]       o_way,
    output logic [7:0]       o_set_index,
    output logic [15:0]      o_tag_value,
    output logic             o_cold_miss,
    output logic             o_repeat_miss,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data
);
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WB    = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [7:0]  r_clr;
    logic [3:0]  r_off, r_idx;
    logic [2:0]  r_pol;
    logic [7:0]  r_set;
    logic [15:0] r_tag;
    logic [15:0] r_addr;

    sact_pkg::t_set set_mem [sact_pkg::MAX_SETS];
    logic [255:0]   seen_mem [256];
    sact_pkg::t_set r_rd_set;
    logic [255:0]   r_rd_seen;

    sact_pkg::t_set upd_set;
    sact_pkg::t_res upd_res;

    logic [3:0]  off, idx;
    logic [4:0]  ofs;
    logic [15:0] sh;
    logic [7:0]  set_c;
    logic [15:0] tag_c;
    logic        take;
    logic        wb_go;
    logic [255:0] seen_row;

    // field split with saturated widths
    always_comb begin
        off   = (r_off > 4'd8) ? 4'd8 : r_off;
        idx   = (r_idx > 4'd8) ? 4'd8 : r_idx;
        ofs   = 5'(off) + 5'(idx);
        sh    = i_address >> off;
        set_c = sh[7:0] & 8'((9'd1 << idx) - 9'd1);
        tag_c = i_address >> ofs;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign take    = i_valid && !o_stall;
    assign wb_go   = (r_state == ST_WB) && (!o_valid || !i_stall);

    always_comb begin
        case (r_state)
            ST_CLEAR: n_state = (r_clr == 8'hFF) ? ST_IDLE : ST_CLEAR;
            ST_IDLE:  n_state = take ? ST_WB : ST_IDLE;
            ST_WB:    n_state = wb_go ? ST_IDLE : ST_WB;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_off   <= 4'd2;
            r_idx   <= 4'd2;
            r_pol   <= sact_pkg::POL_LRU;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sact_pkg::REG_OFFSET: r_off <= i_cfg_data;
                    sact_pkg::REG_INDEX:  r_idx <= i_cfg_data;
                    sact_pkg::REG_POLICY: r_pol <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (wb_go)                o_valid <= 1'b1;
            else if (!i_stall)        o_valid <= 1'b0;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_set  <= set_c;
            r_tag  <= tag_c;
            r_addr <= i_address;
        end
    end

    // set memory and seen memory: cleared after reset, read on accept, write on write-back
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            set_mem[r_clr]  <= '0;
            seen_mem[r_clr] <= '0;
        end else if (wb_go) begin
            set_mem[r_set]          <= upd_set;
            seen_mem[r_addr[15:8]]  <= seen_row;
        end
        if (take) begin
            r_rd_set  <= set_mem[set_c];
            r_rd_seen <= seen_mem[i_address[15:8]];
        end
    end

    always_comb begin
        seen_row = r_rd_seen;
        seen_row[r_addr[7:0]] = 1'b1;
    end

    sact_update u_upd (
        .i_set    (r_rd_set),
        .i_tag    (r_tag),
        .i_policy (r_pol),
        .o_set    (upd_set),
        .o_res    (upd_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (wb_go) begin
            o_hit         <= upd_res.hit;
            o_way         <= upd_res.way;
            o_set_index   <= r_set;
            o_tag_value   <= r_tag;
            o_cold_miss   <= !upd_res.hit && !r_rd_seen[r_addr[7:0]];
            o_repeat_miss <= !upd_res.hit && r_rd_seen[r_addr[7:0]];
        end
    end

    `SACT_ASSERT_IMP(a_no_take_busy, r_state != ST_IDLE, !take, "request taken while busy")
    `SACT_ASSERT_IMP(a_miss_excl, o_valid, !(o_cold_miss && o_repeat_miss), "both miss kinds")
    `SACT_ASSERT_IMP(a_hit_nomiss, o_valid && o_hit, !o_cold_miss && !o_repeat_miss,
                     "miss flag on hit")
    `SACT_ASSERT_NXT(a_wb_out, wb_go, o_valid, "write-back without result")
endmodule
`default_nettype wire
